FILE: sv/exyz_pkg.sv
package exyz_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CS_W  = 34;              // CORDIC x/y/z width (Q2.30 with headroom)
    localparam int TRIG_W = 32;             // cos/sin width after quadrant mapping
    localparam int VEC_W = 34;              // intermediate component width
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [24:0] DEG_TO_RAD = 25'd18740330;

    typedef logic signed [CS_W-1:0] t_cs;

    // Sine/cosine pair for one axis.
    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } t_trig;

    function automatic logic signed [CS_W-1:0] atan_q30(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
                3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
                6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
                9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
               12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
               15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
               18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
               21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
               24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
               27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
               30: t = 32'h00000001;
               default: t = 32'h0;
            endcase
            return $signed({2'b00, t});
        end
    endfunction

endpackage

FILE: sv/euler_xyz_vector_rotation.sv
// Euler XYZ rotation pipeline.
// Throughput: one beat per cycle; the whole pipeline advances unless the output is held.
// Three trig lanes run in parallel; the merge is three chained plane rotations.
// Reset (synchronous, active low) clears the valid pipeline only.
module euler_xyz_vector_rotation #(
    parameter int CORDIC_STAGES = exyz_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = exyz_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_angle_x,
    input  logic signed [31:0] i_angle_y,
    input  logic signed [31:0] i_angle_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_rot_x,
    output logic signed [31:0] o_rot_y,
    output logic signed [31:0] o_rot_z,
    output logic               o_saturated
);
    localparam int TRIG_LAT = CORDIC_STAGES + 6;
    localparam int LAT = TRIG_LAT + 6;
    localparam int VW = exyz_pkg::VEC_W;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    exyz_pkg::t_trig trig_x, trig_y, trig_z;
    exyz_trig #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_tx (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_x), .o_trig(trig_x));
    exyz_trig #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_ty (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_y), .o_trig(trig_y));
    exyz_trig #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_tz (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_z), .o_trig(trig_z));

    // delay the vector alongside the trig lanes
    logic signed [31:0] r_vx [TRIG_LAT+2];
    logic signed [31:0] r_vy [TRIG_LAT];
    logic signed [31:0] r_vz [TRIG_LAT];
    exyz_pkg::t_trig r_ty [2];
    exyz_pkg::t_trig r_tz [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx[0] <= i_vec_x; r_vy[0] <= i_vec_y; r_vz[0] <= i_vec_z;
            for (int k = 1; k < TRIG_LAT; k++) begin
                r_vy[k] <= r_vy[k-1]; r_vz[k] <= r_vz[k-1];
            end
            for (int k = 1; k < TRIG_LAT + 2; k++) r_vx[k] <= r_vx[k-1];
            r_ty[0] <= trig_y; r_ty[1] <= r_ty[0];
            r_tz[0] <= trig_z;
            for (int k = 1; k < 4; k++) r_tz[k] <= r_tz[k-1];
        end
    end

    // about X: (y1, z1) from (vy, vz)
    logic signed [VW-1:0] y1, z1, x2, z2, x3, y3;
    exyz_mix u_mx (.i_clk(i_clk), .i_en(en), .i_trig(trig_x),
        .i_a(VW'(r_vy[TRIG_LAT-1])), .i_b(VW'(r_vz[TRIG_LAT-1])), .o_u(y1), .o_v(z1));
    // about Y: x2 = cy*vx + sy*z1 ; z2 = -sy*vx + cy*z1  => u=(z1,vx) gives cz1 - s vx
    exyz_mix u_my (.i_clk(i_clk), .i_en(en), .i_trig(r_ty[1]),
        .i_a(z1), .i_b(VW'(r_vx[TRIG_LAT+1])), .o_u(z2), .o_v(x2));
    logic signed [VW-1:0] r_y1 [2];
    logic signed [VW-1:0] r_z2 [2];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y1[0] <= y1; r_y1[1] <= r_y1[0];
            r_z2[0] <= z2; r_z2[1] <= r_z2[0];
        end
    end
    exyz_mix u_mz (.i_clk(i_clk), .i_en(en), .i_trig(r_tz[3]),
        .i_a(x2), .i_b(r_y1[1]), .o_u(x3), .o_v(y3));

    function automatic logic [32:0] clamp(input logic signed [VW-1:0] v);
        begin
            if (v > 34'sd2147483647)       return {1'b1, 32'h7FFFFFFF};
            else if (v < -34'sd2147483648) return {1'b1, 32'h80000000};
            else                           return {1'b0, v[31:0]};
        end
    endfunction

    logic [32:0] cx, cy, cz;
    assign cx = clamp(x3);
    assign cy = clamp(y3);
    assign cz = clamp(r_z2[1]);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_vld[LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_rot_x <= $signed(cx[31:0]);
            o_rot_y <= $signed(cy[31:0]);
            o_rot_z <= $signed(cz[31:0]);
            o_saturated <= cx[32] | cy[32] | cz[32];
        end
    end

    hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rot_x)) else $error("output not held");
    stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without result");
    vld_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> o_valid == $past(r_vld[LAT-1])) else $error("valid pipe slip");
endmodule

FILE: sv/exyz_trig.sv
// One lane: angle reduction, pipelined CORDIC, quadrant mapping.
// Advances when i_en is high.
module exyz_trig #(
    parameter int CORDIC_STAGES = exyz_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = exyz_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [31:0]    i_angle,
    output exyz_pkg::t_trig       o_trig
);
    localparam int DW  = 32 - FRAC_BITS;       // whole-degree bits, signed
    localparam int DDW = DW + 10;              // width for the turn subtraction
    localparam int PRW = DW + 28;              // reciprocal product width
    localparam int RSH = 34;
    localparam logic signed [27:0] RECIP = 28'sd47721859;  // ceil(2^34 / 360)
    localparam int MW  = FRAC_BITS + 7;        // remainder below 90 degrees
    localparam int PW  = MW + 25;

    logic signed [31:0]    r_a;
    logic signed [DW-1:0]  r_k;
    logic [9:0]            r_d;
    logic [FRAC_BITS-1:0]  r_fr;
    logic [MW-1:0]         r_m;
    logic [1:0]            r_q1, r_q2;
    logic [PW-1:0]         r_p;
    logic signed [PRW-1:0] n_prod;
    logic signed [DDW-1:0] n_d;
    logic [8:0]            n_dm;
    logic [6:0]            n_md;
    logic [1:0]            n_q;

    // Estimate whole turns from a reciprocal product; one turn short at most.
    assign n_prod = PRW'($signed(i_angle[31:FRAC_BITS])) * PRW'(RECIP);

    // Whole degrees left after the estimated turns, in [0, 360].
    assign n_d = DDW'($signed(r_a[31:FRAC_BITS])) - DDW'(r_k) * DDW'(360);

    // Fold the extra turn, then split into quadrant and remainder.
    always_comb begin
        n_dm = (r_d >= 10'd360) ? 9'(r_d - 10'd360) : r_d[8:0];
        if (n_dm >= 9'd270) begin
            n_q  = 2'd3;
            n_md = 7'(n_dm - 9'd270);
        end else if (n_dm >= 9'd180) begin
            n_q  = 2'd2;
            n_md = 7'(n_dm - 9'd180);
        end else if (n_dm >= 9'd90) begin
            n_q  = 2'd1;
            n_md = 7'(n_dm - 9'd90);
        end else begin
            n_q  = 2'd0;
            n_md = n_dm[6:0];
        end
    end

    // Reduction front: turns, remainder, quadrant split, radians.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= i_angle;
            r_k  <= DW'(n_prod >>> RSH);
            r_d  <= n_d[9:0];
            r_fr <= r_a[FRAC_BITS-1:0];
            r_m  <= {n_md, r_fr};
            r_q1 <= n_q;
            r_p  <= PW'(r_m) * PW'(exyz_pkg::DEG_TO_RAD) + (PW'(1) << (FRAC_BITS - 1));
            r_q2 <= r_q1;
        end
    end

    // CORDIC pipeline
    exyz_pkg::t_cs r_x [CORDIC_STAGES+1];
    exyz_pkg::t_cs r_y [CORDIC_STAGES+1];
    exyz_pkg::t_cs r_z [CORDIC_STAGES+1];
    logic [1:0]    r_q [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= exyz_pkg::CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= $signed(34'(r_p >> FRAC_BITS));
            r_q[0] <= r_q2;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - exyz_pkg::atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + exyz_pkg::atan_q30(g);
                end
                r_q[g+1] <= r_q[g];
            end
        end
    end

    // quadrant map
    exyz_pkg::t_cs fx, fy;
    assign fx = r_x[CORDIC_STAGES];
    assign fy = r_y[CORDIC_STAGES];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[CORDIC_STAGES])
                2'd0: begin o_trig.c <= 32'(fx);  o_trig.s <= 32'(fy);  end
                2'd1: begin o_trig.c <= 32'(-fy); o_trig.s <= 32'(fx);  end
                2'd2: begin o_trig.c <= 32'(-fx); o_trig.s <= 32'(-fy); end
                default: begin o_trig.c <= 32'(fy); o_trig.s <= 32'(-fx); end
            endcase
        end
    end
endmodule

FILE: sv/exyz_mix.sv
// Rotation in one plane: two products per output, registered, then sum and round.
module exyz_mix (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  exyz_pkg::t_trig              i_trig,
    input  logic signed [exyz_pkg::VEC_W-1:0] i_a,
    input  logic signed [exyz_pkg::VEC_W-1:0] i_b,
    output logic signed [exyz_pkg::VEC_W-1:0] o_u,
    output logic signed [exyz_pkg::VEC_W-1:0] o_v
);
    logic signed [65:0] r_ca, r_sb, r_sa, r_cb;
    logic signed [67:0] su, sv;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca <= 66'(i_trig.c) * 66'(i_a);
            r_sb <= 66'(i_trig.s) * 66'(i_b);
            r_sa <= 66'(i_trig.s) * 66'(i_a);
            r_cb <= 66'(i_trig.c) * 66'(i_b);
        end
    end
    // u = c*a - s*b, v = s*a + c*b
    assign su = 68'(r_ca) - 68'(r_sb) + 68'sd536870912;
    assign sv = 68'(r_sa) + 68'(r_cb) + 68'sd536870912;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_u <= exyz_pkg::VEC_W'(su >>> 30);
            o_v <= exyz_pkg::VEC_W'(sv >>> 30);
        end
    end
endmodule

FILE: tb/euler_xyz_vector_rotation_chk.sv
`timescale 1ns / 1ps

module euler_xyz_vector_rotation_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_angle_x,
    input  logic signed [31:0] i_angle_y,
    input  logic signed [31:0] i_angle_z,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_rot_x,
    input  logic signed [31:0] i_rot_y,
    input  logic signed [31:0] i_rot_z,
    input  logic               i_saturated,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_sat_seen
);
    localparam int NSTAGES = 16;
    localparam int FBITS   = 16;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_rot;

    t_rot rotated_q[$];

    // Arctangent steps in Q2.30.
    function automatic longint atan_step(input int i);
        longint tbl[16] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
        return tbl[i];
    endfunction

    // Reduce degrees, run the CORDIC, map the quadrant.
    function automatic void trig(input longint deg, output longint c, output longint s);
        longint full, quarter, r, q, m, x, y, z, nx;
        full = longint'(360) <<< FBITS;
        quarter = longint'(90) <<< FBITS;
        r = deg % full;
        if (r < 0) r += full;
        q = r / quarter;
        m = r - q * quarter;
        z = (m * 18740330 + (longint'(1) <<< (FBITS - 1))) >>> FBITS;
        x = 652032874;
        y = 0;
        for (int i = 0; i < NSTAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_step(i);
            end
            x = nx;
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint blend(longint p, longint a, longint q, longint b);
        return (p * a + q * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic logic [31:0] clamp(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_rot rotate_xyz(longint vx, longint vy, longint vz,
                                        longint ax, longint ay, longint az);
        longint cx, sx, cy, sy, cz, sz, y1, z1, x2, z2, x3, y3;
        t_rot r;
        logic sat;
        trig(ax, cx, sx);
        trig(ay, cy, sy);
        trig(az, cz, sz);
        y1 = blend(cx, vy, -sx, vz);
        z1 = blend(sx, vy, cx, vz);
        x2 = blend(cy, vx, sy, z1);
        z2 = blend(-sy, vx, cy, z1);
        x3 = blend(cz, x2, -sz, y1);
        y3 = blend(sz, x2, cz, y1);
        sat = 1'b0;
        r.x = clamp(x3, sat);
        r.y = clamp(y3, sat);
        r.z = clamp(z2, sat);
        r.sat = sat;
        return r;
    endfunction

    // Predict on each input beat, compare on each output beat.
    always @(posedge i_clk) begin
        t_rot exp_r;
        t_rot got;
        if (!i_rst_n) begin
            rotated_q.delete();
            o_errors = 0;
            o_results = 0;
            o_sat_seen = 0;
        end else begin
            if (i_valid && !i_stall)
                rotated_q.push_back(rotate_xyz(i_vec_x, i_vec_y, i_vec_z,
                                               i_angle_x, i_angle_y, i_angle_z));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_rot_x, i_rot_y, i_rot_z, i_saturated};
                o_results++;
                if (i_saturated) o_sat_seen++;
                if (rotated_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected beat: %0d %0d %0d sat=%0b",
                                 got.x, got.y, got.z, got.sat);
                end else begin
                    exp_r = rotated_q.pop_front();
                    if (got !== exp_r) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: exp %0d %0d %0d sat=%0b got %0d %0d %0d sat=%0b",
                                     exp_r.x, exp_r.y, exp_r.z, exp_r.sat,
                                     got.x, got.y, got.z, got.sat);
                    end
                end
            end
        end
        o_pending = rotated_q.size();
    end
endmodule

FILE: tb/euler_xyz_vector_rotation_tb.sv
`timescale 1ns / 1ps

module euler_xyz_vector_rotation_tb;
    localparam int LATENCY = 16 + 13;
    localparam int LIMIT   = 400000;
    localparam int DEG     = 65536;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic signed [31:0] i_angle_x = '0, i_angle_y = '0, i_angle_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_rot_x, o_rot_y, o_rot_z;
    logic               o_saturated;

    int errors, pending, results, sat_seen;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int cycle = 0;
    int sent = 0;

    euler_xyz_vector_rotation u_top (.*);

    euler_xyz_vector_rotation_chk u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall(o_stall),
        .i_vec_x, .i_vec_y, .i_vec_z, .i_angle_x, .i_angle_y, .i_angle_z,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_rot_x(o_rot_x), .i_rot_y(o_rot_y), .i_rot_z(o_rot_z),
        .i_saturated(o_saturated),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_sat_seen(sat_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bound the run.
    always @(posedge i_clk) begin
        cycle++;
        if (cycle > LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("euler_xyz_vector_rotation_tb NOT OK");
            $finish;
        end
    end

    // Drive receiver stall: a long hold when requested, otherwise random.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return $signed($urandom_range(720 * 4)) * (DEG / 4) - 360 * DEG;
            default: return $urandom;
        endcase
    endfunction

    // Send one beat, idling first at the current rate.
    task automatic send(input logic [31:0] vx, vy, vz, ax, ay, az);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_vec_x <= vx; i_vec_y <= vy; i_vec_z <= vz;
        i_angle_x <= ax; i_angle_y <= ay; i_angle_z <= az;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, zero angles, quadrant edges, negatives.
        send(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
        send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0);
        send(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
        send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 45 * DEG, 45 * DEG, 45 * DEG);
        send(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 30 * DEG, 60 * DEG, 45 * DEG);
        send(32'h0001_0000, 0, 0, 90 * DEG, 180 * DEG, 270 * DEG);
        send(0, 32'h0001_0000, 0, 360 * DEG, -90 * DEG, -180 * DEG);
        send(0, 0, 32'h0001_0000, -270 * DEG, 720 * DEG, -1);
        send(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send(32'hFFFFFFFF, 1, 32'h5555_5555, 89 * DEG + 65535, 1, 32'hAAAAAAAA);
        send(32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F,
             -45 * DEG, -135 * DEG, 315 * DEG);
        drain();

        // Random phases: varying idle and stall rates.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (ph == 4) hold_cycles = 300;
            for (int n = 0; n < 315; n++)
                send(rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word());
            // Pause the sender until every result is back.
            if (ph == 2) drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (LATENCY + 4) @(negedge i_clk);

        $display("sent %0d beats, checked %0d results, %0d saturated",
                 sent, results, sat_seen);
        if (errors == 0 && pending == 0)
            $display("euler_xyz_vector_rotation_tb OK");
        else
            $display("euler_xyz_vector_rotation_tb NOT OK");
        $finish;
    end
endmodule
